### rtl/core/hmqp_pkg.sv
// Shared types, widths and codes of the quadratic-probing hash table.
`timescale 1ns / 1ps
package hmqp_pkg;

  // Capacity of the slot memory.
  localparam int unsigned TABLE_SLOTS = 64;

  // Field widths of the request and result channels.
  localparam int unsigned ACT_W = 2;
  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned OCC_W = 7;

  // Slot address, slot count and remainder unit widths.
  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_STEPS = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_PAD_W = DIV_STEPS * DIV_BITS;
  localparam int unsigned DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(61);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_OCC   = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [1:0]       st;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_FINISH
  } state_e;

endpackage

### rtl/core/hash_map_quadratic_probing_core.sv
// Top level of the open-addressing key-value table with quadratic probing.
`timescale 1ns / 1ps
// This block is a key-value table of TABLE_SLOTS slots held in one synchronous slot RAM
// (key, value and slot state per word) plus one flip-flop per slot that marks it written,
// so a slot never written reads as empty and no clearing pass is needed after reset.
// One request is worked on at a time: after acceptance the home slot, key modulo the
// active slot count n, comes from a remainder unit that reduces four key bits per
// cycle, then the probe walk visits home + i*i modulo n at one slot RAM read per
// cycle, and the final state writes the slot back and loads the result register.
// A request with an unknown action skips the walk. A new request is taken as soon
// as the previous result sits in the output register, even if the downstream side
// still stalls it. Probing stops at the first empty slot, at the matching key, or
// after n probes; an insert takes the matching slot, else the first tombstone or
// empty slot seen, else answers table full. The slot count register is written over
// its own valid/ready port and is sampled when a request is accepted; a value of
// zero acts as one and values above TABLE_SLOTS act as TABLE_SLOTS. Writes to the
// slot RAM happen only in the final state of a request, and the next request reads
// the RAM only after its remainder step, so reads and writes never collide.
module hash_map_quadratic_probing_core
  import hmqp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  // Request channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STS_W-1:0]        status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [OCC_W-1:0]        occupied_count_o
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] slots_q;

  // Request registers.
  logic [ACT_W-1:0] act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] nm1_q;
  logic [CNT_W-1:0] n_eff;

  // Remainder unit.
  logic             div_done;
  logic [IDX_W-1:0] div_rem;

  // Probe issue side.
  logic             iss_on_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W:0]   step_q;
  logic [CNT_W-1:0] iss_cnt_q;
  logic [CNT_W+1:0] idx_sum;
  logic [CNT_W+1:0] idx_red1;
  logic [CNT_W+1:0] idx_red2;

  // Probe evaluation side, aligned with the RAM read data.
  logic             ev_valid_q;
  logic [IDX_W-1:0] ev_idx_q;
  logic             ev_last_q;
  logic             ev_live_q;
  logic [1:0]       ev_st;
  logic             ev_match;
  logic             ev_free;
  logic             ev_stop;

  // Walk outcome.
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [VAL_W-1:0] hit_val_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;

  logic [TABLE_SLOTS-1:0] slot_live_q;
  logic [CNT_W-1:0]       entry_q, entry_d;

  // Slot RAM.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  slot_t            ram_rdata;

  // Result register.
  logic             out_valid_q;
  logic [STS_W-1:0] out_status_q;
  logic [VAL_W-1:0] out_value_q;
  logic [OCC_W-1:0] out_occ_q;
  logic             out_load;
  logic [STS_W-1:0] res_status;
  logic [VAL_W-1:0] res_value;

  logic accept;
  logic act_known;
  logic finish_fire;

  hmqp_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_i),
    .n_i     (n_eff),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  hmqp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_load    = !out_valid_q || !out_stall_i;
  assign finish_fire = (state_q == S_FINISH) && out_load;
  assign act_known   = (act_q == ACT_INSERT) || (act_q == ACT_DELETE) ||
                       (act_q == ACT_LOOKUP);

  // Effective slot count: zero acts as one, oversize values clamp to the capacity.
  always_comb begin
    if (slots_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(slots_q) > CMP_W'(TABLE_SLOTS)) begin
      n_eff = CNT_W'(TABLE_SLOTS);
    end else begin
      n_eff = CNT_W'(slots_q);
    end
  end

  // Next probe address: (idx + 2i + 1) mod n, the sum stays below 3n.
  always_comb begin
    idx_sum  = (CNT_W + 2)'(idx_q) + (CNT_W + 2)'(step_q);
    idx_red1 = (idx_sum >= (CNT_W + 2)'(n_q)) ? idx_sum - (CNT_W + 2)'(n_q) : idx_sum;
    idx_red2 = (idx_red1 >= (CNT_W + 2)'(n_q)) ? idx_red1 - (CNT_W + 2)'(n_q) : idx_red1;
  end

  // Decode of the slot that just came back from the RAM.
  always_comb begin
    ev_st    = ev_live_q ? ram_rdata.st : SLOT_EMPTY;
    ev_match = (ev_st == SLOT_OCC) && (ram_rdata.key == key_q);
    ev_free  = (ev_st != SLOT_OCC);
    ev_stop  = ev_match || (ev_st == SLOT_EMPTY) || ev_last_q;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (div_done) begin
          state_d = act_known ? S_PROBE : S_FINISH;
        end
      end
      S_PROBE: begin
        if (ev_valid_q && ev_stop) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Final write-back and result of the request.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = '{key: key_q, value: val_q, st: SLOT_OCC};
    entry_d    = entry_q;
    res_status = RES_NOT_FOUND;
    res_value  = '0;
    unique case (act_q)
      ACT_INSERT: begin
        if (hit_q) begin
          ram_we     = finish_fire;
          res_status = RES_OK;
        end else if (free_found_q) begin
          ram_we     = finish_fire;
          ram_waddr  = free_idx_q;
          entry_d    = entry_q + 1'b1;
          res_status = RES_OK;
        end else begin
          res_status = RES_FULL;
        end
      end
      ACT_DELETE: begin
        if (hit_q) begin
          ram_we       = finish_fire;
          ram_wdata.st = SLOT_TOMB;
          if (entry_q != '0) begin
            entry_d = entry_q - 1'b1;
          end
          res_status = RES_OK;
        end
      end
      ACT_LOOKUP: begin
        if (hit_q) begin
          res_status = RES_OK;
          res_value  = hit_val_q;
        end
      end
      default: res_status = RES_NOT_FOUND;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slots_q      <= SLOTS_RESET;
      iss_on_q     <= 1'b0;
      iss_cnt_q    <= '0;
      ev_valid_q   <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      slot_live_q  <= '0;
      entry_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slots_q <= cfg_wdata_i;
      end

      if ((state_q == S_HASH) && div_done) begin
        iss_on_q     <= act_known;
        iss_cnt_q    <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end

      if (state_q == S_PROBE) begin
        if (iss_on_q) begin
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
        // A stopping probe ends the walk and drops any read still in flight.
        if (ev_valid_q && ev_stop) begin
          iss_on_q   <= 1'b0;
          ev_valid_q <= 1'b0;
        end else begin
          ev_valid_q <= iss_on_q;
          if (iss_on_q && (iss_cnt_q == nm1_q)) begin
            iss_on_q <= 1'b0;
          end
        end
        if (ev_valid_q) begin
          if (ev_match) begin
            hit_q <= 1'b1;
          end
          if (ev_free && !free_found_q) begin
            free_found_q <= 1'b1;
          end
        end
      end else begin
        ev_valid_q <= 1'b0;
      end

      if (finish_fire) begin
        entry_q     <= entry_d;
        out_valid_q <= 1'b1;
        if (ram_we) begin
          slot_live_q[ram_waddr] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      key_q <= key_i;
      val_q <= value_i;
      n_q   <= n_eff;
      nm1_q <= n_eff - 1'b1;
    end
    if ((state_q == S_HASH) && div_done) begin
      idx_q  <= div_rem;
      step_q <= (CNT_W + 1)'(1);
    end else if ((state_q == S_PROBE) && iss_on_q) begin
      idx_q     <= IDX_W'(idx_red2);
      step_q    <= step_q + (CNT_W + 1)'(2);
      ev_idx_q  <= idx_q;
      ev_last_q <= (iss_cnt_q == nm1_q);
      ev_live_q <= slot_live_q[idx_q];
    end
    if ((state_q == S_PROBE) && ev_valid_q) begin
      if (ev_match) begin
        hit_idx_q <= ev_idx_q;
        hit_val_q <= ram_rdata.value;
      end
      if (ev_free && !free_found_q) begin
        free_idx_q <= ev_idx_q;
      end
    end
    if (finish_fire) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
      out_occ_q    <= OCC_W'(entry_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign read_value_o     = out_value_q;
  assign occupied_count_o = out_occ_q;

  // The live entry count can never exceed the number of slots.
  a_entry_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(TABLE_SLOTS) >= entry_q)
    else $error("live entry count exceeds table capacity");

  // A result is only ever loaded from the final state of a request.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(out_valid_q) || !$past(out_stall_i)) && out_valid_q
      |-> $past(state_q == S_FINISH))
    else $error("result register loaded outside the final state");

  // The probe walk never issues more reads than the active slot count.
  a_probe_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (iss_cnt_q <= n_q))
    else $error("probe walk issued more reads than slots in use");

  // A slot RAM write only happens together with a result leaving the final state.
  a_write_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("slot write not followed by a loaded result");

endmodule

### rtl/core/hmqp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module hmqp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/hmqp_mod.sv
// Iterative remainder unit that reduces a key modulo the active slot count.
`timescale 1ns / 1ps
module hmqp_mod
  import hmqp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [CNT_W-1:0] n_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_PAD_W-1:0] sh_q, sh_d;
  logic [CNT_W:0]       rem_q, rem_d;
  logic [CNT_W:0]       n_q, n_d;
  logic [CNT_W:0]       r_step;

  // Restoring remainder, a few key bits per cycle; the partial remainder stays below n.
  always_comb begin
    r_step = rem_q;
    for (int j = 0; j < DIV_BITS; j++) begin
      r_step = {r_step[CNT_W-1:0], sh_q[DIV_PAD_W-1-j]};
      if (r_step >= n_q) begin
        r_step = r_step - n_q;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    n_d    = n_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = DIV_PAD_W'(key_i);
      rem_d  = '0;
      n_d    = (CNT_W + 1)'(n_i);
    end else if (busy_q) begin
      rem_d = r_step;
      sh_d  = sh_q << DIV_BITS;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    n_q   <= n_d;
  end

  assign done_o = done_q;
  assign rem_o  = IDX_W'(rem_q);

endmodule

### tb/hmqp_table_checker.sv
// Checker that mirrors the hash table, predicts each reply and compares it with the block.
`timescale 1ns / 1ps
module hmqp_table_checker
  import hmqp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [STS_W-1:0]        status_o,
  input  logic signed [VAL_W-1:0] read_value_o,
  input  logic [OCC_W-1:0]        occupied_count_o,
  output int                      err_cnt_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] read_value;
    logic [OCC_W-1:0] occupied;
  } reply_t;

  // Shadow copy of the table and of the slot count register.
  logic [KEY_W-1:0] shadow_key [TABLE_SLOTS];
  logic [VAL_W-1:0] shadow_val [TABLE_SLOTS];
  slot_e            shadow_st  [TABLE_SLOTS];
  int unsigned      live_entries;
  logic [CFG_W-1:0] slots_reg;

  reply_t replies_q [$];
  reply_t oldest;
  int     mismatches;

  function automatic int unsigned active_slots();
    int unsigned n;
    n = slots_reg;
    if (n == 0) n = 1;
    if (n > TABLE_SLOTS) n = TABLE_SLOTS;
    return n;
  endfunction

  // Walks the quadratic probe path. Returns the slot holding the key or -1, and
  // reports the first tombstone or empty slot met on the way in reuse_slot.
  function automatic int find_key(input logic [KEY_W-1:0] key, output int reuse_slot);
    longint unsigned n;
    longint unsigned home;
    longint unsigned idx;
    n = active_slots();
    home = longint'(key) % n;
    reuse_slot = -1;
    for (longint unsigned i = 0; i < n; i++) begin
      idx = (home + i * i) % n;
      if (shadow_st[idx] == SLOT_EMPTY) begin
        if (reuse_slot < 0) reuse_slot = int'(idx);
        return -1;
      end else if (shadow_st[idx] == SLOT_OCC) begin
        if (shadow_key[idx] == key) return int'(idx);
      end else if (reuse_slot < 0) begin
        reuse_slot = int'(idx);
      end
    end
    return -1;
  endfunction

  function automatic reply_t apply_table_op(input logic [ACT_W-1:0] act,
                                            input logic [KEY_W-1:0] key,
                                            input logic [VAL_W-1:0] val);
    reply_t r;
    int     hit;
    int     reuse_slot;
    r.status = RES_NOT_FOUND;
    r.read_value = '0;
    case (act)
      ACT_INSERT: begin
        hit = find_key(key, reuse_slot);
        if (hit >= 0) begin
          shadow_val[hit] = val;
          r.status = RES_OK;
        end else if (reuse_slot >= 0) begin
          shadow_key[reuse_slot] = key;
          shadow_val[reuse_slot] = val;
          shadow_st[reuse_slot] = SLOT_OCC;
          live_entries++;
          r.status = RES_OK;
        end else begin
          r.status = RES_FULL;
        end
      end
      ACT_DELETE: begin
        hit = find_key(key, reuse_slot);
        if (hit >= 0) begin
          shadow_st[hit] = SLOT_TOMB;
          if (live_entries > 0) live_entries--;
          r.status = RES_OK;
        end
      end
      ACT_LOOKUP: begin
        hit = find_key(key, reuse_slot);
        if (hit >= 0) begin
          r.read_value = shadow_val[hit];
          r.status = RES_OK;
        end
      end
      default: begin
        // Unknown action leaves the table alone.
      end
    endcase
    r.occupied = live_entries[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_SLOTS; s++) shadow_st[s] = SLOT_EMPTY;
      live_entries = 0;
      slots_reg = SLOTS_RESET;
      replies_q.delete();
      mismatches = 0;
    end else begin
      // Replies are matched first; a reply can never belong to a request taken at this edge.
      if (out_valid_o && !out_stall_i) begin
        if (replies_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply with none awaited: status %0d value %0d count %0d",
                     $time, status_o, read_value_o, occupied_count_o);
        end else begin
          oldest = replies_q.pop_front();
          if (status_o !== oldest.status || read_value_o !== oldest.read_value ||
              occupied_count_o !== oldest.occupied) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected status %0d value %0d count %0d, got %0d %0d %0d",
                       $time, oldest.status, $signed(oldest.read_value), oldest.occupied,
                       status_o, read_value_o, occupied_count_o);
          end
        end
      end
      // A request taken at this edge still sees the slot count from before the edge.
      if (in_valid_i && !in_stall_o)
        replies_q.push_back(apply_table_op(action_i, key_i, value_i));
      if (cfg_valid_i && cfg_ready_o) slots_reg = cfg_wdata_i;
    end
    err_cnt_o = mismatches;
    pending_o = replies_q.size();
  end

endmodule

### tb/tb_top.sv
// Top of the hash table testbench: clock, reset, request and slot count stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
  import hmqp_pkg::*;

  // Action code 3 is not defined by the block; it must answer not found and change nothing.
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLDOFF_AT     = 500;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_FROM     = 800;
  localparam int QUIET_TO       = 1100;
  localparam int DRAIN_CYCLES   = 200;
  // About 1525 requests, plus idle gaps and stalls, end well within this limit.
  localparam int CYCLE_LIMIT    = 1000000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ACT_W-1:0]        action_i;
  logic [KEY_W-1:0]        key_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STS_W-1:0]        status_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic [OCC_W-1:0]        occupied_count_o;

  int err_cnt;
  int pending;
  int sent_cnt;
  bit holdoff_done;

  // Slot counts for the random phases: tiny tables that fill up and report full,
  // zero and oversized settings that get clamped, and the full table.
  logic [CFG_W-1:0] phase_slots [PHASES] = '{7'd5, 7'd1, 7'd0, 7'd16, 7'd64,
                                             7'd127, 7'd2, 7'd61, 7'd12, 7'd64};

  // Keys reused within a phase, so that updates, deletes, lookups and tombstones
  // actually meet keys that are in the table.
  logic [KEY_W-1:0] key_pool [TABLE_SLOTS + 4];

  hash_map_quadratic_probing_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .occupied_count_o (occupied_count_o)
  );

  hmqp_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .occupied_count_o (occupied_count_o),
    .err_cnt_o        (err_cnt),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both sides run without any idling while the request count is inside this window.
  function automatic bit no_idle();
    return sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO;
  endfunction

  // Offers one request starting at a falling edge and returns at the falling edge
  // after it was taken. Valid is dropped only for an idle gap, never between two
  // back-to-back requests, so it is assigned at most once per time step.
  task automatic issue(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                       input logic [VAL_W-1:0] val);
    if (!no_idle() && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Writes the slot count only once the block is idle: every request taken so far
  // has produced its reply, and each request produces exactly one.
  task automatic write_slots(input logic [CFG_W-1:0] n);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_wdata_i <= n;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiving side: random stalls, a quiet window, and one long hold-off that lets
  // the single output register fill so the block has to stall its request side.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && sent_cnt >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        out_stall_i <= 1'b1;
        for (int c = 0; c < HOLDOFF_CYCLES; c++) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (no_idle()) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 7);
      end
    end
  end

  // Run limit.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int               sel;
    int               n_eff;
    int               pool_n;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_INSERT;
    key_i       = '0;
    value_i     = '0;
    sent_cnt    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset slot count of 61. Keys 0, 61, 122 and 183 share
    // home slot 0, so they build a probe chain that deletes turn into tombstones.
    issue(ACT_LOOKUP, '0, '0);                      // miss in an empty table
    issue(ACT_DELETE, 31'd5, '0);                   // delete of a missing key
    issue(ACT_INSERT, '0, 32'h7FFF_FFFF);
    issue(ACT_INSERT, 31'h7FFF_FFFF, 32'h8000_0000);
    issue(ACT_INSERT, 31'd61, 32'hFFFF_FFFF);
    issue(ACT_INSERT, 31'd122, 32'h1234_5678);
    issue(ACT_LOOKUP, 31'd61, '0);
    issue(ACT_INSERT, 31'd61, '0);                  // update of a present key
    issue(ACT_LOOKUP, 31'd61, '0);
    issue(ACT_DELETE, 31'd61, '0);                  // leaves a tombstone mid-chain
    issue(ACT_LOOKUP, 31'd122, '0);                 // must walk past the tombstone
    issue(ACT_INSERT, 31'd122, 32'h0BAD_F00D);      // key behind a tombstone updates in place
    issue(ACT_INSERT, 31'd183, 32'h5555_AAAA);      // new key reuses the tombstone
    issue(ACT_LOOKUP, 31'h7FFF_FFFF, '0);
    issue(ACT_DELETE, 31'h7FFF_FFFF, '0);
    issue(ACT_DELETE, 31'h7FFF_FFFF, '0);           // second delete misses
    issue(ACT_RESERVED, '0, 32'hFFFF_FFFF);
    issue(ACT_LOOKUP, '0, '0);
    // Slot count zero acts as one while the table still holds entries: only slot 0
    // is probed, so a new key finds the path full.
    write_slots(7'd0);
    issue(ACT_INSERT, 31'd9, 32'hAAAA_5555);
    issue(ACT_LOOKUP, '0, '0);
    issue(ACT_INSERT, '0, 32'h0000_0001);
    // An oversized slot count is clamped to the full table.
    write_slots(7'd127);
    issue(ACT_LOOKUP, 31'd122, '0);
    issue(ACT_INSERT, 31'd63, 32'h8000_0001);
    issue(ACT_LOOKUP, 31'd183, '0);

    // Random phases, each at its own slot count; entries carry over between them.
    for (int p = 0; p < PHASES; p++) begin
      write_slots(phase_slots[p]);
      n_eff = phase_slots[p];
      if (n_eff == 0) n_eff = 1;
      if (n_eff > TABLE_SLOTS) n_eff = TABLE_SLOTS;
      pool_n = n_eff + 4;
      for (int j = 0; j < pool_n; j++)
        key_pool[j] = $urandom_range(1) ? KEY_W'($urandom_range(4 * n_eff)) : KEY_W'($urandom());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sel = $urandom_range(99);
        if (sel < 60) key = key_pool[$urandom_range(pool_n - 1)];
        else if (sel < 75) key = KEY_W'($urandom_range(4 * n_eff));
        else key = KEY_W'($urandom());
        sel = $urandom_range(99);
        if (sel < 50) act = ACT_INSERT;
        else if (sel < 68) act = ACT_DELETE;
        else if (sel < 95) act = ACT_LOOKUP;
        else act = ACT_RESERVED;
        sel = $urandom_range(19);
        if (sel == 0) val = 32'h8000_0000;
        else if (sel == 1) val = 32'h7FFF_FFFF;
        else val = $urandom();
        issue(act, key, val);
      end
    end

    // Let every reply come back, then watch a while longer for stray replies.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
